[src/voxel_region_dirty_tracker_macros.svh]
// assertion macros shared by the checker
`ifndef VOXEL_REGION_DIRTY_TRACKER_MACROS_SVH
`define VOXEL_REGION_DIRTY_TRACKER_MACROS_SVH

// checked only outside reset
`define VRDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define VRDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/vrdt_pkg.sv]
package vrdt_pkg;

  localparam logic [2:0] OP_TRACKED = 3'd0;
  localparam logic [2:0] OP_LOCKED  = 3'd1;
  localparam logic [2:0] OP_LOCK    = 3'd2;
  localparam logic [2:0] OP_UNLOCK  = 3'd3;
  localparam logic [2:0] OP_SETALL  = 3'd4;
  localparam logic [2:0] OP_FIND    = 3'd5;

  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_ALREADY    = 2'd1;
  localparam logic [1:0] STS_NOT_LOCKED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLAN,
    S_READ,
    S_MODIFY,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic plan;
    logic rd;
    logic rmw_wr;
    logic fill_wr;
    logic step;
    logic record;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic do_rows;
    logic do_fill;
    logic is_find;
    logic hit;
    logic row_last;
  } sts_t;

endpackage

[src/vrdt_ctrl.sv]
module vrdt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  vrdt_pkg::sts_t sts,
  output vrdt_pkg::cmd_t cmd
);

  vrdt_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != vrdt_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vrdt_pkg::S_CLEAR:  if (sts.row_last) state_nxt = vrdt_pkg::S_IDLE;
      vrdt_pkg::S_IDLE:   if (in_valid) state_nxt = vrdt_pkg::S_PLAN;
      vrdt_pkg::S_PLAN: begin
        if (sts.do_fill) state_nxt = vrdt_pkg::S_FILL;
        else if (sts.do_rows) state_nxt = vrdt_pkg::S_READ;
        else state_nxt = vrdt_pkg::S_DONE;
      end
      vrdt_pkg::S_READ:   state_nxt = vrdt_pkg::S_MODIFY;
      vrdt_pkg::S_MODIFY: begin
        if (sts.hit || sts.row_last) state_nxt = vrdt_pkg::S_DONE;
        else state_nxt = vrdt_pkg::S_READ;
      end
      vrdt_pkg::S_FILL:   if (sts.row_last) state_nxt = vrdt_pkg::S_DONE;
      vrdt_pkg::S_DONE:   if (out_free) state_nxt = vrdt_pkg::S_IDLE;
      default:            state_nxt = vrdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      vrdt_pkg::S_CLEAR: begin
        cmd.fill_wr = 1'b1;
        cmd.step    = !sts.row_last;
      end
      vrdt_pkg::S_IDLE:   cmd.capture = in_valid;
      vrdt_pkg::S_PLAN:   cmd.plan = 1'b1;
      vrdt_pkg::S_READ:   cmd.rd = 1'b1;
      vrdt_pkg::S_MODIFY: begin
        if (sts.is_find) begin
          cmd.record = sts.hit;
          cmd.step   = !sts.hit && !sts.row_last;
        end else begin
          cmd.rmw_wr = 1'b1;
          cmd.step   = !sts.row_last;
        end
      end
      vrdt_pkg::S_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.step    = !sts.row_last;
      end
      vrdt_pkg::S_DONE:   cmd.load_out = out_free;
      default:            cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vrdt_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/vrdt_datapath.sv]
module vrdt_datapath #(
  parameter int REGION_SIDE_LOG2 = 4,
  parameter int REGIONS_PER_SIDE = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  vrdt_pkg::cmd_t cmd,
  output vrdt_pkg::sts_t sts,
  input  logic [2:0]     in_opcode,
  input  logic [7:0]     in_coord_x,
  input  logic [7:0]     in_coord_y,
  input  logic [7:0]     in_coord_z,
  input  logic [8:0]     in_upper_x,
  input  logic [8:0]     in_upper_y,
  input  logic [8:0]     in_upper_z,
  input  logic [7:0]     in_voxel_value,
  input  logic           in_up_to_date,
  output logic [1:0]     out_status,
  output logic           out_store_write,
  output logic [7:0]     out_store_x,
  output logic [7:0]     out_store_y,
  output logic [7:0]     out_store_z,
  output logic [7:0]     out_store_value,
  output logic           out_region_found,
  output logic [3:0]     out_region_x,
  output logic [3:0]     out_region_y,
  output logic [3:0]     out_region_z
);

  localparam int R  = REGIONS_PER_SIDE;
  localparam int RW = (R > 1) ? $clog2(R) : 1;
  localparam int AW = 2 * RW;
  localparam int DEPTH = 1 << AW;
  localparam logic [7:0]    LAST8 = 8'(R - 1);
  localparam logic [8:0]    LAST9 = 9'(R - 1);
  localparam logic [RW-1:0] LASTR = RW'(R - 1);
  localparam logic [7:0]    FACE8 = 8'((1 << REGION_SIDE_LOG2) - 1);

  // captured item
  logic [2:0] op_r;
  logic [7:0] cx_r, cy_r, cz_r, val_r;
  logic [8:0] ux_r, uy_r, uz_r;
  logic       utd_r;

  // lock box
  logic       lock_act_r;
  logic [7:0] lo_x_r, lo_y_r, lo_z_r;
  logic [8:0] hi_x_r, hi_y_r, hi_z_r;

  // row walk
  logic [RW-1:0] y_r, z_r, y_lo_r, y_hi_r, z_hi_r;
  logic [R-1:0]  mask_r;
  logic          fill_val_r, find_r;
  logic [R-1:0]  rd_data_r;
  logic [R-1:0]  mem [0:DEPTH-1];

  // result
  logic [1:0] res_status_r;
  logic       res_sw_r, res_found_r;
  logic [7:0] res_x_r, res_y_r, res_z_r, res_val_r;
  logic [3:0] res_rx_r, res_ry_r, res_rz_r;

  logic [1:0] o_status_r;
  logic       o_sw_r, o_found_r;
  logic [7:0] o_x_r, o_y_r, o_z_r, o_val_r;
  logic [3:0] o_rx_r, o_ry_r, o_rz_r;

  function automatic logic [7:0] sat8(input logic [7:0] v);
    sat8 = (v > LAST8) ? LAST8 : v;
  endfunction

  function automatic logic on_face(input logic [7:0] c);
    on_face = ((c & FACE8) == 8'd0) || ((c & FACE8) == FACE8);
  endfunction

  // plan of the captured item
  logic [7:0] rx, ry, rz;
  logic       face;
  logic [7:0] ul_lo_x, ul_lo_y, ul_lo_z, ul_hi_x, ul_hi_y, ul_hi_z;
  logic [8:0] sh_x, sh_y, sh_z;
  logic [7:0] p_xlo, p_xhi, p_ylo, p_ystart, p_yhi, p_zlo, p_zhi;
  logic       p_rows, p_fill, p_find, p_sw;
  logic [1:0] p_status;
  logic [R-1:0] p_mask;

  always_comb begin
    rx   = sat8(cx_r >> REGION_SIDE_LOG2);
    ry   = sat8(cy_r >> REGION_SIDE_LOG2);
    rz   = sat8(cz_r >> REGION_SIDE_LOG2);
    face = on_face(cx_r) || on_face(cy_r) || on_face(cz_r);
    ul_lo_x = lo_x_r >> REGION_SIDE_LOG2;
    ul_lo_y = lo_y_r >> REGION_SIDE_LOG2;
    ul_lo_z = lo_z_r >> REGION_SIDE_LOG2;
    sh_x = hi_x_r >> REGION_SIDE_LOG2;
    sh_y = hi_y_r >> REGION_SIDE_LOG2;
    sh_z = hi_z_r >> REGION_SIDE_LOG2;
    ul_hi_x = (sh_x > LAST9) ? LAST8 : sh_x[7:0];
    ul_hi_y = (sh_y > LAST9) ? LAST8 : sh_y[7:0];
    ul_hi_z = (sh_z > LAST9) ? LAST8 : sh_z[7:0];

    p_xlo = 8'd0; p_xhi = 8'd0; p_ylo = 8'd0; p_ystart = 8'd0;
    p_yhi = 8'd0; p_zlo = 8'd0; p_zhi = 8'd0;
    p_rows = 1'b0; p_fill = 1'b0; p_find = 1'b0; p_sw = 1'b0;
    p_status = vrdt_pkg::STS_OK;
    case (op_r)
      vrdt_pkg::OP_TRACKED: begin
        p_sw   = 1'b1;
        p_rows = 1'b1;
        if (face) begin
          p_xlo = (rx != 8'd0) ? rx - 8'd1 : 8'd0;
          p_ylo = (ry != 8'd0) ? ry - 8'd1 : 8'd0;
          p_zlo = (rz != 8'd0) ? rz - 8'd1 : 8'd0;
          p_xhi = sat8(rx + 8'd1);
          p_yhi = sat8(ry + 8'd1);
          p_zhi = sat8(rz + 8'd1);
        end else begin
          p_xlo = rx; p_ylo = ry; p_zlo = rz;
          p_xhi = rx; p_yhi = ry; p_zhi = rz;
        end
        p_ystart = p_ylo;
      end
      vrdt_pkg::OP_LOCKED: begin
        p_sw = 1'b1;
        if (!lock_act_r) p_status = vrdt_pkg::STS_NOT_LOCKED;
      end
      vrdt_pkg::OP_LOCK: begin
        if (lock_act_r) p_status = vrdt_pkg::STS_ALREADY;
      end
      vrdt_pkg::OP_UNLOCK: begin
        if (!lock_act_r) begin
          p_status = vrdt_pkg::STS_NOT_LOCKED;
        end else begin
          p_xlo = ul_lo_x; p_ylo = ul_lo_y; p_zlo = ul_lo_z;
          p_xhi = ul_hi_x; p_yhi = ul_hi_y; p_zhi = ul_hi_z;
          p_ystart = p_ylo;
          // empty box in any axis clears nothing
          p_rows = (ul_lo_x <= ul_hi_x) && (ul_lo_y <= ul_hi_y) && (ul_lo_z <= ul_hi_z);
        end
      end
      vrdt_pkg::OP_SETALL: p_fill = 1'b1;
      vrdt_pkg::OP_FIND: begin
        if ((cx_r <= LAST8) && (cy_r <= LAST8) && (cz_r <= LAST8)) begin
          p_rows = 1'b1;
          p_find = 1'b1;
          p_xlo = cx_r; p_xhi = LAST8;
          p_ylo = 8'd0; p_ystart = cy_r; p_yhi = LAST8;
          p_zlo = cz_r; p_zhi = LAST8;
        end
      end
      default: p_status = vrdt_pkg::STS_OK;
    endcase

    for (int i = 0; i < R; i++) begin
      p_mask[i] = (8'(i) >= p_xlo) && (8'(i) <= p_xhi);
    end
  end

  // row search
  logic [R-1:0]  zeros;
  logic [RW-1:0] idx;
  logic [7:0]    idx8, y8, z8;
  logic          row_last;

  always_comb begin
    zeros = ~rd_data_r & mask_r;
    idx   = '0;
    for (int i = R - 1; i >= 0; i--) begin
      if (zeros[i]) idx = RW'(i);
    end
    idx8 = 8'(idx);
    y8   = 8'(y_r);
    z8   = 8'(z_r);
  end

  assign row_last     = (y_r == y_hi_r) && (z_r == z_hi_r);
  assign sts.row_last = row_last;
  assign sts.do_rows  = p_rows;
  assign sts.do_fill  = p_fill;
  assign sts.is_find  = find_r;
  assign sts.hit      = find_r && (|zeros);

  // memory port
  logic [AW-1:0] addr;
  logic          wr_en;
  logic [R-1:0]  wr_data;

  assign addr    = {z_r, y_r};
  assign wr_en   = cmd.rmw_wr || cmd.fill_wr;
  assign wr_data = cmd.fill_wr ? {R{fill_val_r}} : (rd_data_r & ~mask_r);

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data_r <= mem[addr];
    if (wr_en) mem[addr] <= wr_data;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r        <= '0;
      z_r        <= '0;
      y_lo_r     <= '0;
      y_hi_r     <= LASTR;
      z_hi_r     <= LASTR;
      fill_val_r <= 1'b0;
      find_r     <= 1'b0;
      lock_act_r <= 1'b0;
      lo_x_r <= '0; lo_y_r <= '0; lo_z_r <= '0;
      hi_x_r <= '0; hi_y_r <= '0; hi_z_r <= '0;
    end else begin
      if (cmd.plan) begin
        // set-all leaves the plan bounds at zero, so the fill starts at row zero
        y_r        <= RW'(p_ystart);
        z_r        <= RW'(p_zlo);
        y_lo_r     <= RW'(p_ylo);
        y_hi_r     <= p_fill ? LASTR : RW'(p_yhi);
        z_hi_r     <= p_fill ? LASTR : RW'(p_zhi);
        fill_val_r <= utd_r;
        find_r     <= p_find;
        if ((op_r == vrdt_pkg::OP_LOCK) && !lock_act_r) begin
          lock_act_r <= 1'b1;
          lo_x_r <= cx_r; lo_y_r <= cy_r; lo_z_r <= cz_r;
          hi_x_r <= ux_r; hi_y_r <= uy_r; hi_z_r <= uz_r;
        end
        if ((op_r == vrdt_pkg::OP_UNLOCK) && lock_act_r) lock_act_r <= 1'b0;
      end else if (cmd.step) begin
        if (y_r == y_hi_r) begin
          y_r <= y_lo_r;
          z_r <= RW'(z_r + 1'b1);
        end else begin
          y_r <= RW'(y_r + 1'b1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      cx_r  <= in_coord_x; cy_r <= in_coord_y; cz_r <= in_coord_z;
      ux_r  <= in_upper_x; uy_r <= in_upper_y; uz_r <= in_upper_z;
      val_r <= in_voxel_value;
      utd_r <= in_up_to_date;
    end
    if (cmd.plan) begin
      mask_r       <= p_mask;
      res_status_r <= p_status;
      res_sw_r     <= p_sw;
      res_x_r      <= p_sw ? cx_r : 8'd0;
      res_y_r      <= p_sw ? cy_r : 8'd0;
      res_z_r      <= p_sw ? cz_r : 8'd0;
      res_val_r    <= p_sw ? val_r : 8'd0;
      res_found_r  <= 1'b0;
      res_rx_r     <= 4'd0;
      res_ry_r     <= 4'd0;
      res_rz_r     <= 4'd0;
    end else if (cmd.record) begin
      res_found_r <= 1'b1;
      res_rx_r    <= idx8[3:0];
      res_ry_r    <= y8[3:0];
      res_rz_r    <= z8[3:0];
    end else if (cmd.step && find_r) begin
      // rows after the start row are searched whole
      mask_r <= '1;
    end
    if (cmd.load_out) begin
      o_status_r <= res_status_r;
      o_sw_r     <= res_sw_r;
      o_x_r      <= res_x_r;
      o_y_r      <= res_y_r;
      o_z_r      <= res_z_r;
      o_val_r    <= res_val_r;
      o_found_r  <= res_found_r;
      o_rx_r     <= res_rx_r;
      o_ry_r     <= res_ry_r;
      o_rz_r     <= res_rz_r;
    end
  end

  assign out_status       = o_status_r;
  assign out_store_write  = o_sw_r;
  assign out_store_x      = o_x_r;
  assign out_store_y      = o_y_r;
  assign out_store_z      = o_z_r;
  assign out_store_value  = o_val_r;
  assign out_region_found = o_found_r;
  assign out_region_x     = o_rx_r;
  assign out_region_y     = o_ry_r;
  assign out_region_z     = o_rz_r;

endmodule

[src/voxel_region_dirty_tracker.sv]
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    opcode, coords, upper corner, value, up_to_date
// out_      output     out_valid / out_stall  status, store write, region found and index
//
// one item at a time: the item is captured in IDLE and planned in PLAN, then each region row
// touched is read then written back or searched, and the result is loaded last
// tracked write: one row inside a region, up to 9 on a face; set-all: all R*R rows;
// find-next: rows in turn up to the first hit, through the single read port of the row memory
// after reset a clearing pass zeroes all R*R rows, in_stall held high
// a waiting result sits in the output register, so the next item is taken meanwhile
module voxel_region_dirty_tracker #(
  parameter int REGION_SIDE_LOG2 = 4,
  parameter int REGIONS_PER_SIDE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_coord_x,
  input  logic [7:0] in_coord_y,
  input  logic [7:0] in_coord_z,
  input  logic [8:0] in_upper_x,
  input  logic [8:0] in_upper_y,
  input  logic [8:0] in_upper_z,
  input  logic [7:0] in_voxel_value,
  input  logic       in_up_to_date,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_store_write,
  output logic [7:0] out_store_x,
  output logic [7:0] out_store_y,
  output logic [7:0] out_store_z,
  output logic [7:0] out_store_value,
  output logic       out_region_found,
  output logic [3:0] out_region_x,
  output logic [3:0] out_region_y,
  output logic [3:0] out_region_z
);

  // command and status between sequencer and row datapath
  vrdt_pkg::cmd_t cmd;
  vrdt_pkg::sts_t sts;

  vrdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // one memory row per (y, z), one bit per region along x
  vrdt_datapath #(
    .REGION_SIDE_LOG2 (REGION_SIDE_LOG2),
    .REGIONS_PER_SIDE (REGIONS_PER_SIDE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_upper_x       (in_upper_x),
    .in_upper_y       (in_upper_y),
    .in_upper_z       (in_upper_z),
    .in_voxel_value   (in_voxel_value),
    .in_up_to_date    (in_up_to_date),
    .out_status       (out_status),
    .out_store_write  (out_store_write),
    .out_store_x      (out_store_x),
    .out_store_y      (out_store_y),
    .out_store_z      (out_store_z),
    .out_store_value  (out_store_value),
    .out_region_found (out_region_found),
    .out_region_x     (out_region_x),
    .out_region_y     (out_region_y),
    .out_region_z     (out_region_z)
  );

endmodule

[src/vrdt_checker.sv]
`include "voxel_region_dirty_tracker_macros.svh"

module vrdt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic       out_store_write,
  input logic       out_region_found
);

  `VRDT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_status), "stalled result dropped or changed")
  `VRDT_ASSERT(a_found_clean, out_valid && out_region_found |-> !out_store_write && out_status == vrdt_pkg::STS_OK, "find result carries write or error")
  `VRDT_ASSERT(a_write_status, out_valid && out_store_write |-> out_status != vrdt_pkg::STS_ALREADY, "voxel write reports already locked")
  `VRDT_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")
  `VRDT_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> in_stall, "item taken during clearing pass")

endmodule

bind voxel_region_dirty_tracker vrdt_checker u_vrdt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_store_write  (out_store_write),
  .out_region_found (out_region_found)
);
